// ----- rtl/gasc_pkg.sv -----
// shared widths and register indexes for the glyph atlas slot cache
`timescale 1ns / 1ps

package gasc_pkg;

  localparam int CODE_W    = 16;
  localparam int SLOT_W    = 14;
  localparam int TILE_W    = 13;
  localparam int GSIZE_W   = 7;
  localparam int SPR_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_PER_ROW = 2'd1;

  localparam logic [GSIZE_W-1:0] GLYPH_SIZE_RST    = 7'd16;
  localparam logic [SPR_W-1:0]   SLOTS_PER_ROW_RST = 8'd16;

endpackage

// ----- rtl/gasc_req_if.sv -----
// request channel: one character code per item
`timescale 1ns / 1ps

interface gasc_req_if;
  logic                         valid;
  logic                         ready;
  logic [gasc_pkg::CODE_W-1:0]  char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

// ----- rtl/gasc_rsp_if.sv -----
// response channel: slot and tile position per item
`timescale 1ns / 1ps

interface gasc_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [gasc_pkg::SLOT_W-1:0]  slot_index;
  logic [gasc_pkg::TILE_W-1:0]  tile_x;
  logic [gasc_pkg::TILE_W-1:0]  tile_y;
  logic                         hit;
  logic                         flushed;

  modport source (output valid, output slot_index, output tile_x, output tile_y,
                  output hit, output flushed, input ready);
  modport sink   (input valid, input slot_index, input tile_x, input tile_y,
                  input hit, input flushed, output ready);
endinterface

// ----- rtl/gasc_div.sv -----
// bit-serial restoring divider: slot number by slots per row
`timescale 1ns / 1ps

module gasc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [gasc_pkg::SLOT_W-1:0]   dividend,
  input  logic [gasc_pkg::SPR_W-1:0]    divisor,
  output logic                          done,
  output logic [gasc_pkg::SLOT_W-1:0]   quo,
  output logic [gasc_pkg::SPR_W-1:0]    rem
);

  localparam int DW = gasc_pkg::SLOT_W;
  localparam int RW = gasc_pkg::SPR_W;
  localparam int NW = $clog2(DW);

  logic          busy;
  logic [NW-1:0] cnt;
  logic [DW-1:0] dvd;
  logic [RW-1:0] dvs;
  logic [RW:0]   shifted;
  logic          take;

  assign shifted = {rem, dvd[DW-1]};
  assign take    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
        quo  <= '0;
      end else if (busy) begin
        dvd <= {dvd[DW-2:0], 1'b0};
        quo <= {quo[DW-2:0], take};
        if (take) begin
          rem <= RW'(shifted - {1'b0, dvs});
        end else begin
          rem <= shifted[RW-1:0];
        end
        if (cnt == NW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/glyph_atlas_slot_cache.sv -----
// glyph atlas slot cache top level: slot store, scan sequencer, tile position
`timescale 1ns / 1ps
//
// req carries one character code per item, rsp returns one item per request:
// the slot that holds or was given the code, the tile texel position of that
// slot, hit, and flushed when the store was full and had to be cleared.
// glyph_size and slots_per_row are written through cfg_we / cfg_index /
// cfg_data; other indexes are ignored. The user is to write them only while
// the block is idle; the block itself does not enforce this. A request scans
// the slots up to capacity one per cycle through the single read port of the
// slot store; the next request can be taken once the result is loaded.
// Capacity is slots_per_row squared (zero counts as one), clipped to SLOTS.
// A hit ends the scan early. A full store adds a flush of all SLOTS slots.
// The tail is a 14-step serial divide and two passes of one small multiplier.
// req.ready is high only between items; one item is in work at a time.
// After reset the store is cleared before the first request is taken.
// A result waits in the output register while rsp.ready is low, and the next
// request may already be accepted; its result waits until the first is taken.
//
module glyph_atlas_slot_cache #(
  parameter int SLOTS = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gasc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gasc_pkg::CFG_DAT_W-1:0]  cfg_data,
  gasc_req_if.sink                        req,
  gasc_rsp_if.source                      rsp
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int PW = 2 * gasc_pkg::SPR_W;
  localparam int MW = gasc_pkg::SLOT_W + gasc_pkg::GSIZE_W;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_DIVST = 3'd4;
  localparam logic [2:0] S_DIVW  = 3'd5;
  localparam logic [2:0] S_MULX  = 3'd6;
  localparam logic [2:0] S_MULY  = 3'd7;

  logic [gasc_pkg::CODE_W-1:0] slot_keys [0:SLOTS-1];

  logic [2:0]                     state;
  logic [gasc_pkg::GSIZE_W-1:0]   glyph_size;
  logic [gasc_pkg::SPR_W-1:0]     slots_per_row;
  logic [gasc_pkg::SPR_W-1:0]     row_len;
  logic [gasc_pkg::CODE_W-1:0]    code;
  logic [CW-1:0]                  cap;
  logic [CW-1:0]                  addr;
  logic                           rd_vld;
  logic [AW-1:0]                  rd_idx;
  logic [gasc_pkg::CODE_W-1:0]    rd_data;
  logic                           empty_found;
  logic [AW-1:0]                  empty_idx;
  logic [AW-1:0]                  clr;
  logic [gasc_pkg::SLOT_W-1:0]    slot;
  logic                           hit;
  logic                           flushed;
  logic [gasc_pkg::TILE_W-1:0]    tile_x;

  logic                           rsp_valid;
  logic [gasc_pkg::SLOT_W-1:0]    rsp_slot;
  logic [gasc_pkg::TILE_W-1:0]    rsp_tx;
  logic [gasc_pkg::TILE_W-1:0]    rsp_ty;
  logic                           rsp_hit;
  logic                           rsp_flushed;

  logic [gasc_pkg::SPR_W-1:0]     row_len_next;
  logic [PW-1:0]                  cap_prod;
  logic [CW-1:0]                  cap_next;
  logic                           wr_en;
  logic [AW-1:0]                  wr_addr;
  logic [gasc_pkg::CODE_W-1:0]    wr_data;
  logic                           div_start;
  logic                           div_done;
  logic [gasc_pkg::SLOT_W-1:0]    div_quo;
  logic [gasc_pkg::SPR_W-1:0]     div_rem;
  logic [gasc_pkg::SLOT_W-1:0]    mul_a;
  logic [MW-1:0]                  mul_p;
  logic                           rsp_free;
  logic                           rd_match;
  logic                           scan_end;

  assign row_len_next = (slots_per_row == '0) ? gasc_pkg::SPR_W'(1) : slots_per_row;
  assign cap_prod     = PW'(row_len_next) * PW'(row_len_next);
  assign cap_next     = (cap_prod > PW'(SLOTS)) ? CW'(SLOTS) : CW'(cap_prod);

  assign rd_match  = rd_vld && (rd_data == code);
  assign scan_end  = !rd_vld && (addr == cap);
  assign div_start = (state == S_DIVST);
  assign rsp_free  = !rsp_valid || rsp.ready;

  assign mul_a = (state == S_MULX) ? gasc_pkg::SLOT_W'(div_rem) : div_quo;
  assign mul_p = MW'(mul_a) * MW'(glyph_size);

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = rsp_valid;
  assign rsp.slot_index = rsp_slot;
  assign rsp.tile_x     = rsp_tx;
  assign rsp.tile_y     = rsp_ty;
  assign rsp.hit        = rsp_hit;
  assign rsp.flushed    = rsp_flushed;

  gasc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (slot),
    .divisor  (row_len),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // store write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr;
    wr_data = '0;
    unique case (state)
      S_INIT: begin
        wr_en = 1'b1;
      end
      S_FLUSH: begin
        wr_en = 1'b1;
        if (clr == '0) begin
          wr_data = code;
        end
      end
      S_SCAN: begin
        if (!rd_match && scan_end && empty_found) begin
          wr_en   = 1'b1;
          wr_addr = empty_idx;
          wr_data = code;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_keys[wr_addr] <= wr_data;
    end
    rd_data <= slot_keys[addr[AW-1:0]];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_size    <= gasc_pkg::GLYPH_SIZE_RST;
      slots_per_row <= gasc_pkg::SLOTS_PER_ROW_RST;
    end else if (cfg_we) begin
      if (cfg_index == gasc_pkg::REG_GLYPH_SIZE) begin
        glyph_size <= cfg_data[gasc_pkg::GSIZE_W-1:0];
      end else if (cfg_index == gasc_pkg::REG_SLOTS_PER_ROW) begin
        slots_per_row <= cfg_data[gasc_pkg::SPR_W-1:0];
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      clr       <= '0;
      rd_vld    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready && (state != S_MULY)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          if (clr == AW'(SLOTS - 1)) begin
            state <= S_IDLE;
          end else begin
            clr <= clr + 1'b1;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            code        <= req.char_code;
            row_len     <= row_len_next;
            cap         <= cap_next;
            addr        <= '0;
            rd_vld      <= 1'b0;
            empty_found <= 1'b0;
            state       <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_vld <= (addr < cap);
          rd_idx <= addr[AW-1:0];
          if (addr < cap) begin
            addr <= addr + 1'b1;
          end
          priority if (rd_match) begin
            slot    <= gasc_pkg::SLOT_W'(rd_idx);
            hit     <= 1'b1;
            flushed <= 1'b0;
            state   <= S_DIVST;
          end else if (scan_end) begin
            hit     <= 1'b0;
            flushed <= 1'b0;
            if (empty_found) begin
              slot  <= gasc_pkg::SLOT_W'(empty_idx);
              state <= S_DIVST;
            end else begin
              clr   <= '0;
              state <= S_FLUSH;
            end
          end else if (rd_vld && (rd_data == '0) && !empty_found) begin
            empty_found <= 1'b1;
            empty_idx   <= rd_idx;
          end
        end
        S_FLUSH: begin
          if (clr == AW'(SLOTS - 1)) begin
            slot    <= '0;
            flushed <= 1'b1;
            state   <= S_DIVST;
          end else begin
            clr <= clr + 1'b1;
          end
        end
        S_DIVST: begin
          state <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            state <= S_MULX;
          end
        end
        S_MULX: begin
          tile_x <= mul_p[gasc_pkg::TILE_W-1:0];
          state  <= S_MULY;
        end
        S_MULY: begin
          if (rsp_free) begin
            rsp_valid   <= 1'b1;
            rsp_slot    <= slot;
            rsp_tx      <= tile_x;
            rsp_ty      <= mul_p[gasc_pkg::TILE_W-1:0];
            rsp_hit     <= hit;
            rsp_flushed <= flushed;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_hit_not_flushed: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_hit && rsp_flushed))
    else $error("hit and flushed both set");

  a_flush_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_flushed) |-> (rsp_slot == '0))
    else $error("flushed result not in slot 0");

  a_scan_in_cap: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && rd_vld) |-> (CW'(rd_idx) < cap))
    else $error("scan beyond capacity");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVW))
    else $error("divider finished outside wait state");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_MULY && rsp_free) |=> (rsp_valid && state == S_IDLE))
    else $error("result not loaded");
`endif

endmodule

// ----- tb/sv/tb.sv -----
// self-checking testbench for the glyph atlas slot cache
`timescale 1ns / 1ps

module tb;

  localparam int CACHE_SLOTS = 256;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 2000;
  localparam int DRAIN_CYCLES = 600;
  localparam int MAX_REPORTS = 10;

  localparam logic [gasc_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [gasc_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum int {
    IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
  } idle_mode_t;

  typedef struct {
    logic [gasc_pkg::CODE_W-1:0] code;
    logic [gasc_pkg::SLOT_W-1:0] slot;
    logic [gasc_pkg::TILE_W-1:0] x;
    logic [gasc_pkg::TILE_W-1:0] y;
    logic                        hit;
    logic                        flushed;
  } tile_answer_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [gasc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [gasc_pkg::CFG_DAT_W-1:0] cfg_data;

  gasc_req_if req_ch ();
  gasc_rsp_if rsp_ch ();

  glyph_atlas_slot_cache #(
    .SLOTS(CACHE_SLOTS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the cache state and registers
  logic [gasc_pkg::CODE_W-1:0]  slot_key [CACHE_SLOTS];
  logic [gasc_pkg::GSIZE_W-1:0] tile_edge;
  logic [gasc_pkg::SPR_W-1:0]   atlas_row;

  logic [gasc_pkg::CODE_W-1:0] glyph_queue [$];
  tile_answer_t                answer_queue [$];
  logic [gasc_pkg::CODE_W-1:0] code_pool [$];
  int pool_next;
  int fresh_pct;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_tokens = 0;
  int hold_done = 0;
  int hold_left = 0;
  logic req_took = 1'b0;
  int fail_count = 0;
  int quiet_cycles = 0;

  function automatic tile_answer_t lookup_glyph(input logic [gasc_pkg::CODE_W-1:0] code);
    tile_answer_t ans;
    int row;
    int cap;
    int slot;
    int x_full;
    int y_full;
    bit found;
    bit empty_found;
    row = (atlas_row == '0) ? 1 : int'(atlas_row);
    cap = row * row;
    if (cap > CACHE_SLOTS) cap = CACHE_SLOTS;
    slot = 0;
    found = 1'b0;
    empty_found = 1'b0;
    ans.code = code;
    ans.flushed = 1'b0;
    for (int i = 0; i < cap; i++) begin
      if (!found && slot_key[i] == code) begin
        slot = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      for (int i = 0; i < cap; i++) begin
        if (!empty_found && slot_key[i] == '0) begin
          slot = i;
          empty_found = 1'b1;
        end
      end
      if (!empty_found) begin
        for (int i = 0; i < CACHE_SLOTS; i++) slot_key[i] = '0;
        slot = 0;
        ans.flushed = 1'b1;
      end
      slot_key[slot] = code;
    end
    x_full = (slot % row) * int'(tile_edge);
    y_full = (slot / row) * int'(tile_edge);
    ans.slot = slot[gasc_pkg::SLOT_W-1:0];
    ans.x = x_full[gasc_pkg::TILE_W-1:0];
    ans.y = y_full[gasc_pkg::TILE_W-1:0];
    ans.hit = found;
    return ans;
  endfunction

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !req_took) begin
      req_ch.valid <= 1'b1;
    end else if (glyph_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      req_ch.valid <= 1'b1;
      req_ch.char_code <= glyph_queue[0];
    end else begin
      req_ch.valid <= 1'b0;
      req_ch.char_code <= gasc_pkg::CODE_W'($urandom_range(0, 65535));
    end
  end

  // response ready, with random stalls and long hold-offs
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (hold_done != hold_tokens) begin
      hold_done <= hold_done + 1;
      hold_left <= HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor: predict on accepted requests, check accepted responses
  always @(posedge clk) begin
    tile_answer_t want;
    req_took <= !rst && req_ch.valid && req_ch.ready;
    if (!rst && req_ch.valid && req_ch.ready) begin
      answer_queue.push_back(lookup_glyph(req_ch.char_code));
      if (glyph_queue.size() > 0) glyph_queue.pop_front();
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (answer_queue.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected item: slot %0d x %0d y %0d hit %b flushed %b",
                   rsp_ch.slot_index, rsp_ch.tile_x, rsp_ch.tile_y,
                   rsp_ch.hit, rsp_ch.flushed);
      end else begin
        want = answer_queue.pop_front();
        if (rsp_ch.slot_index !== want.slot || rsp_ch.tile_x !== want.x ||
            rsp_ch.tile_y !== want.y || rsp_ch.hit !== want.hit ||
            rsp_ch.flushed !== want.flushed) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("mismatch code %h: exp %0d %0d %0d %b %b, got %0d %0d %0d %b %b",
                     want.code, want.slot, want.x, want.y, want.hit, want.flushed,
                     rsp_ch.slot_index, rsp_ch.tile_x, rsp_ch.tile_y,
                     rsp_ch.hit, rsp_ch.flushed);
        end
      end
    end
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** glyph_atlas_slot_cache: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(input logic [gasc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gasc_pkg::CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == gasc_pkg::REG_GLYPH_SIZE) tile_edge = val[gasc_pkg::GSIZE_W-1:0];
    else if (idx == gasc_pkg::REG_SLOTS_PER_ROW) atlas_row = val[gasc_pkg::SPR_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (glyph_queue.size() != 0 || answer_queue.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 76;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = 76;
      end
      default: begin
        send_idle_pct = 23;
        recv_stall_pct = 23;
      end
    endcase
  endtask

  task automatic send_alone(input logic [gasc_pkg::CODE_W-1:0] code);
    glyph_queue.push_back(code);
    wait_drained();
  endtask

  function automatic logic [gasc_pkg::CODE_W-1:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 15) return gasc_pkg::CODE_W'($urandom_range(0, 65535));
    if (pool_next < code_pool.size() && $urandom_range(0, 99) < fresh_pct) begin
      pool_next++;
      return code_pool[pool_next - 1];
    end
    if (pool_next == 0) pool_next = 1;
    return code_pool[$urandom_range(0, pool_next - 1)];
  endfunction

  // fresh codes fill the table, repeats give hits, overflow gives flushes
  task automatic run_phase(input logic [gasc_pkg::CFG_DAT_W-1:0] gsize,
                           input logic [gasc_pkg::CFG_DAT_W-1:0] spr,
                           input int n_items, input int pool_n,
                           input int fresh, input idle_mode_t mode);
    wait_drained();
    write_reg(gasc_pkg::REG_GLYPH_SIZE, gsize);
    write_reg(gasc_pkg::REG_SLOTS_PER_ROW, spr);
    set_idling(mode);
    code_pool.delete();
    repeat (pool_n) code_pool.push_back(gasc_pkg::CODE_W'($urandom_range(1, 65535)));
    pool_next = 0;
    fresh_pct = fresh;
    repeat (n_items) glyph_queue.push_back(pick_code());
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.char_code = '0;
    rsp_ch.ready = 1'b0;
    for (int i = 0; i < CACHE_SLOTS; i++) slot_key[i] = '0;
    tile_edge = gasc_pkg::GLYPH_SIZE_RST;
    atlas_row = gasc_pkg::SLOTS_PER_ROW_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, one item at a time at reset settings
    send_alone(16'h0000);
    send_alone(16'hFFFF);
    send_alone(16'hFFFF);
    send_alone(16'h0001);
    send_alone(16'h8000);
    send_alone(16'h00FF);
    send_alone(16'hFF00);
    send_alone(16'h5555);
    send_alone(16'hAAAA);
    send_alone(16'h0000);
    send_alone(16'h0001);

    // shrunk capacity hides upper slots, full table flushes
    write_reg(REG_SPARE_A, 8'hFF);
    write_reg(REG_SPARE_B, 8'h00);
    write_reg(gasc_pkg::REG_GLYPH_SIZE, 8'd64);
    write_reg(gasc_pkg::REG_SLOTS_PER_ROW, 8'd2);
    send_alone(16'hAAAA);
    send_alone(16'h8000);

    // zero row length, zero code on a full table
    write_reg(gasc_pkg::REG_GLYPH_SIZE, 8'hFF);
    write_reg(gasc_pkg::REG_SLOTS_PER_ROW, 8'd0);
    send_alone(16'h0007);
    send_alone(16'h0000);
    send_alone(16'h0000);

    run_phase(8'hFF, 8'd255, 50, 300, 70, IDLE_NONE);
    run_phase(8'd1, 8'd1, 50, 4, 50, IDLE_SENDER);
    run_phase(8'd64, 8'd3, 50, 20, 50, IDLE_RECEIVER);

    // long receiver hold-off while the sender keeps offering
    set_idling(IDLE_NONE);
    hold_tokens = hold_tokens + 1;
    repeat (12) glyph_queue.push_back(gasc_pkg::CODE_W'($urandom_range(0, 65535)));
    wait_drained();

    run_phase(8'd0, 8'd0, 50, 6, 50, IDLE_BOTH);
    run_phase(8'd16, 8'd16, 340, 320, 75, IDLE_RECEIVER);
    run_phase(8'd33, 8'd7, 50, 100, 50, IDLE_BOTH);
    run_phase(8'd64, 8'd128, 50, 80, 50, IDLE_SENDER);
    run_phase(gasc_pkg::CFG_DAT_W'($urandom_range(1, 64)),
              gasc_pkg::CFG_DAT_W'($urandom_range(2, 12)), 50, 40, 50, IDLE_NONE);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && answer_queue.size() == 0) begin
      $display("** glyph_atlas_slot_cache: PASSED **");
    end else begin
      $display("** glyph_atlas_slot_cache: FAILED **");
    end
    $finish;
  end

endmodule
